FILE: rtl/core/bfea_pkg.sv
// ----------------------------------------------------------------------------
// bfea_pkg
// Shared types and constants for the best-fit extent allocator.
// ----------------------------------------------------------------------------
package bfea_pkg;

    localparam int MAX_SLOTS   = 4096;
    localparam int MAX_EXTENTS = 64;
    localparam int STALE_DEPTH = 64;

    localparam int LEN_W   = $clog2(MAX_SLOTS + 1);
    localparam int OFF_W   = $clog2(MAX_SLOTS);
    localparam int EXT_W   = $clog2(MAX_EXTENTS);
    localparam int STALE_W = $clog2(STALE_DEPTH);
    localparam int FILL_W  = $clog2(STALE_DEPTH + 1);
    localparam int SUM_W   = LEN_W + 1;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_ALLOC   = 2'd0;
    localparam cmd_t CMD_FREE    = 2'd1;
    localparam cmd_t CMD_RELEASE = 2'd2;
    localparam cmd_t CMD_PROBE   = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_NO_SPACE   = 2'd1;
    localparam status_t ST_STALE_FULL = 2'd2;
    localparam status_t ST_TABLE_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [LEN_W-1:0] count;
        logic [OFF_W-1:0] slot_offset;
    } bfea_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] grant_offset;
        logic             space_ok;
        logic [LEN_W-1:0] free_slots;
    } bfea_out_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIT_SCAN,
        S_ALLOC_WR,
        S_FREE_PUSH,
        S_REL_LOAD,
        S_REL_SCAN,
        S_REL_WR,
        S_PROBE_SCAN,
        S_DONE
    } bfea_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_start;   // start table clear sweep
        logic capture;       // latch input item
        logic scan_start;    // reset scan index and trackers
        logic scan_step;     // one table entry per cycle
        logic fit_use_stale; // scan tracks fit for current stale length
        logic alloc_write;
        logic free_push;
        logic rel_load;      // read head of stale queue
        logic rel_write;     // apply merge
        logic rel_pop;       // drop head of stale queue
        logic set_table_full;
        logic result_load;
    } bfea_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic scan_last;
        logic fit_found;
        logic req_bad;       // allocate rejected: zero count or more than free slots
        logic stale_full;
        logic stale_empty;
        logic rel_needs_spare_missing;
        cmd_t cmd;
    } bfea_stat_t;

endpackage

FILE: rtl/core/bfea_if.sv
// ----------------------------------------------------------------------------
// bfea_if
// Valid/ready channel carrying one payload item per beat.
// ----------------------------------------------------------------------------
interface bfea_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/best_fit_extent_allocator_unit.sv
// ----------------------------------------------------------------------------
// best_fit_extent_allocator_unit
// Best-fit free-extent allocator with deferred frees and coalescing.
// ----------------------------------------------------------------------------
// One command at a time. The 64-entry extent table is read one entry per
// cycle into a register during a table scan. From the accepting edge to a
// valid result: probe runs a scan, defer free a queue push and a scan,
// allocate a fit scan, the table write, then a scan for space_ok, release a
// load, scan and merge write per stale extent drained, then a final scan. A
// result hand-off and a return to idle pass before the next command is taken.
// After reset and after each heap_size write a clearing pass rebuilds the
// table; no item is taken during it. heap_size is written only while idle.
module best_fit_extent_allocator_unit
    import bfea_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    bfea_if.sink             in_ch,
    bfea_if.source           out_ch
);

    bfea_cmd_t  cmd;
    bfea_stat_t stat;

    bfea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_busy (out_ch.valid && !out_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfea_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_ch.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_data  (out_ch.data)
    );

endmodule

FILE: rtl/core/bfea_ctrl.sv
// ----------------------------------------------------------------------------
// bfea_ctrl
// Command sequencer: table sweeps, queue drain and result hand-off.
// ----------------------------------------------------------------------------
module bfea_ctrl
    import bfea_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_busy,
    input  bfea_stat_t stat,
    output bfea_cmd_t  cmd
);

    bfea_state_t state_reg;
    bfea_state_t state_next;

    // tracks the final fit scan after an allocate write, free push or release drain
    logic post_reg;
    logic post_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    state_next = S_CLEAR;
                end
                else if (in_valid)
                begin
                    state_next = S_PROBE_SCAN;
                end
            end
            S_PROBE_SCAN:
            begin
                // first cycle after capture decides the command path
                state_next = S_PROBE_SCAN;
                case (stat.cmd)
                    CMD_ALLOC:   state_next = stat.req_bad ? S_FIT_SCAN : S_FIT_SCAN;
                    CMD_FREE:    state_next = S_FREE_PUSH;
                    CMD_RELEASE: state_next = S_REL_LOAD;
                    default:     state_next = S_FIT_SCAN;
                endcase
            end
            S_FIT_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = (stat.cmd == CMD_ALLOC && !post_reg && !stat.req_bad
                                  && stat.fit_found) ? S_ALLOC_WR : S_DONE;
                end
            end
            S_ALLOC_WR:
            begin
                state_next = S_FIT_SCAN;
            end
            S_FREE_PUSH:
            begin
                state_next = S_FIT_SCAN;
            end
            S_REL_LOAD:
            begin
                state_next = stat.stale_empty ? S_FIT_SCAN : S_REL_SCAN;
            end
            S_REL_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_REL_WR;
                end
            end
            S_REL_WR:
            begin
                state_next = stat.rel_needs_spare_missing ? S_FIT_SCAN : S_REL_LOAD;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_reg <= 1'b0;
        end
        else
        begin
            post_reg <= post_next;
        end
    end

    always_comb
    begin
        post_next = post_reg;
        if (state_reg == S_IDLE)
        begin
            post_next = 1'b0;
        end
        else if (state_reg == S_ALLOC_WR || state_reg == S_FREE_PUSH
                 || (state_reg == S_REL_LOAD && stat.stale_empty)
                 || (state_reg == S_REL_WR && stat.rel_needs_spare_missing))
        begin
            post_next = 1'b1;
        end
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.scan_step = 1'b1;
            end
            S_IDLE:
            begin
                in_ready = !cfg_we;
                cmd.capture = in_valid && !cfg_we;
                cmd.clear_start = cfg_we;
            end
            S_PROBE_SCAN:
            begin
                cmd.scan_start = 1'b1;
            end
            S_FIT_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last && !(stat.cmd == CMD_ALLOC && !post_reg
                    && !stat.req_bad && stat.fit_found))
                begin
                    cmd.result_load = 1'b1;
                end
            end
            S_ALLOC_WR:
            begin
                cmd.alloc_write = 1'b1;
                cmd.scan_start  = 1'b1;
            end
            S_FREE_PUSH:
            begin
                cmd.free_push  = 1'b1;
                cmd.scan_start = 1'b1;
            end
            S_REL_LOAD:
            begin
                cmd.rel_load   = 1'b1;
                cmd.scan_start = 1'b1;
            end
            S_REL_SCAN:
            begin
                cmd.scan_step     = 1'b1;
                cmd.fit_use_stale = 1'b1;
            end
            S_REL_WR:
            begin
                cmd.rel_write = 1'b1;
                cmd.rel_pop   = !stat.rel_needs_spare_missing;
                cmd.set_table_full = stat.rel_needs_spare_missing;
                cmd.scan_start = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/core/bfea_dp.sv
// ----------------------------------------------------------------------------
// bfea_dp
// Extent table, stale queue, scan trackers and result register.
// ----------------------------------------------------------------------------
module bfea_dp
    import bfea_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LEN_W-1:0] cfg_wdata,
    input  bfea_in_t         in_data,
    input  bfea_cmd_t        cmd,
    output bfea_stat_t       stat,
    input  logic             out_ready,
    output logic             out_valid,
    output bfea_out_t        out_data
);

    // extent table memory, one entry read per cycle into registers
    logic [OFF_W-1:0] ext_start_mem [MAX_EXTENTS];
    logic [LEN_W-1:0] ext_len_mem   [MAX_EXTENTS];
    logic             ext_valid_mem [MAX_EXTENTS];

    // stale queue memory
    logic [OFF_W-1:0] stale_start_mem [STALE_DEPTH];
    logic [LEN_W-1:0] stale_len_mem   [STALE_DEPTH];
    logic [STALE_W-1:0] rd_ptr_reg;
    logic [STALE_W-1:0] wr_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;

    logic [LEN_W-1:0] heap_reg;
    logic [LEN_W-1:0] free_reg;
    bfea_in_t         req_reg;

    // scan state
    logic [EXT_W:0]   idx_reg;
    logic [EXT_W-1:0] ix;
    logic             cur_live_reg;
    logic [EXT_W-1:0] cur_ix_reg;
    logic             cur_v_reg;
    logic [OFF_W-1:0] cur_s_reg;
    logic [LEN_W-1:0] cur_l_reg;
    logic             best_ok_reg;
    logic [EXT_W-1:0] best_reg;
    logic [LEN_W-1:0] best_len_reg;
    logic [OFF_W-1:0] best_start_reg;
    logic             prev_ok_reg, next_ok_reg, spare_ok_reg, ovl_reg;
    logic [EXT_W-1:0] prev_reg, next_reg, spare_reg;
    logic [LEN_W-1:0] prev_len_reg, next_len_reg;
    logic [OFF_W-1:0] s_off_reg;
    logic [LEN_W-1:0] s_len_reg;
    logic             tfull_reg;
    logic             clearing_reg;

    logic [LEN_W-1:0] want;
    logic [SUM_W-1:0] s_end;
    logic [SUM_W-1:0] e_end;
    logic             better;
    logic [LEN_W-1:0] heap_sat;
    logic             s_bad;

    assign ix    = idx_reg[EXT_W-1:0];
    assign want  = cmd.fit_use_stale ? s_len_reg : req_reg.count;
    assign s_end = SUM_W'(s_off_reg) + SUM_W'(s_len_reg);
    assign e_end = SUM_W'(cur_s_reg) + SUM_W'(cur_l_reg);
    assign better = !best_ok_reg || cur_l_reg < best_len_reg
                    || (cur_l_reg == best_len_reg && cur_s_reg < best_start_reg);
    assign heap_sat = (cfg_wdata > LEN_W'(MAX_SLOTS)) ? LEN_W'(MAX_SLOTS) : cfg_wdata;
    assign s_bad = s_len_reg == '0 || s_end > SUM_W'(heap_reg) || ovl_reg;

    // status
    always_comb
    begin
        stat.clear_done  = idx_reg == (EXT_W+1)'(MAX_EXTENTS - 1);
        stat.scan_last   = cur_live_reg && cur_ix_reg == EXT_W'(MAX_EXTENTS - 1);
        stat.fit_found   = best_ok_reg
                           || (cur_live_reg && cur_v_reg && cur_l_reg >= want);
        stat.req_bad     = req_reg.count == '0 || req_reg.count > free_reg;
        stat.stale_full  = fill_reg == FILL_W'(STALE_DEPTH);
        stat.stale_empty = fill_reg == '0;
        stat.rel_needs_spare_missing = !s_bad && !prev_ok_reg && !next_ok_reg
                                       && !spare_ok_reg;
        stat.cmd         = req_reg.cmd;
    end

    // scan index, trackers and free count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            clearing_reg   <= 1'b1;
            heap_reg       <= LEN_W'(MAX_SLOTS);
            free_reg       <= LEN_W'(MAX_SLOTS);
            cur_live_reg   <= 1'b0;
            cur_ix_reg     <= '0;
            best_ok_reg    <= 1'b0;
            best_reg       <= '0;
            best_len_reg   <= '0;
            best_start_reg <= '0;
            prev_ok_reg    <= 1'b0;
            next_ok_reg    <= 1'b0;
            spare_ok_reg   <= 1'b0;
            ovl_reg        <= 1'b0;
            prev_reg       <= '0;
            next_reg       <= '0;
            spare_reg      <= '0;
            prev_len_reg   <= '0;
            next_len_reg   <= '0;
            tfull_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clear_start)
            begin
                idx_reg      <= '0;
                clearing_reg <= 1'b1;
                cur_live_reg <= 1'b0;
                heap_reg     <= heap_sat;
                free_reg     <= heap_sat;
            end
            else if (clearing_reg)
            begin
                // one entry a cycle; entry 0 holds the whole heap
                idx_reg <= idx_reg + 1'b1;
                if (stat.clear_done)
                begin
                    clearing_reg <= 1'b0;
                    idx_reg      <= '0;
                end
            end
            else
            begin
                if (cmd.capture)
                begin
                    tfull_reg <= 1'b0;
                end
                if (cmd.scan_start)
                begin
                    idx_reg      <= '0;
                    cur_live_reg <= 1'b0;
                    best_ok_reg  <= 1'b0;
                    prev_ok_reg  <= 1'b0;
                    next_ok_reg  <= 1'b0;
                    spare_ok_reg <= 1'b0;
                    ovl_reg      <= 1'b0;
                end
                else if (cmd.scan_step)
                begin
                    // read address runs one entry ahead of the compare
                    if (idx_reg < (EXT_W+1)'(MAX_EXTENTS))
                    begin
                        idx_reg      <= idx_reg + 1'b1;
                        cur_ix_reg   <= ix;
                        cur_live_reg <= 1'b1;
                    end
                    else
                    begin
                        cur_live_reg <= 1'b0;
                    end
                    if (cur_live_reg)
                    begin
                        if (cur_v_reg && cur_l_reg >= want && better)
                        begin
                            best_ok_reg    <= 1'b1;
                            best_reg       <= cur_ix_reg;
                            best_len_reg   <= cur_l_reg;
                            best_start_reg <= cur_s_reg;
                        end
                        if (cmd.fit_use_stale)
                        begin
                            if (!cur_v_reg)
                            begin
                                if (!spare_ok_reg)
                                begin
                                    spare_ok_reg <= 1'b1;
                                    spare_reg    <= cur_ix_reg;
                                end
                            end
                            else
                            begin
                                if (SUM_W'(cur_s_reg) < s_end && SUM_W'(s_off_reg) < e_end)
                                begin
                                    ovl_reg <= 1'b1;
                                end
                                if (e_end == SUM_W'(s_off_reg))
                                begin
                                    prev_ok_reg  <= 1'b1;
                                    prev_reg     <= cur_ix_reg;
                                    prev_len_reg <= cur_l_reg;
                                end
                                if (SUM_W'(cur_s_reg) == s_end)
                                begin
                                    next_ok_reg  <= 1'b1;
                                    next_reg     <= cur_ix_reg;
                                    next_len_reg <= cur_l_reg;
                                end
                            end
                        end
                    end
                end
                if (cmd.alloc_write)
                begin
                    free_reg <= free_reg - req_reg.count;
                end
                if (cmd.set_table_full)
                begin
                    tfull_reg <= 1'b1;
                end
                if (cmd.rel_write && !s_bad
                    && (prev_ok_reg || next_ok_reg || spare_ok_reg))
                begin
                    free_reg <= free_reg + s_len_reg;
                end
            end
        end
    end

    // extent table writes and registered entry read
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            ext_valid_mem[ix] <= (ix == '0) && heap_reg != '0;
            ext_start_mem[ix] <= '0;
            ext_len_mem[ix]   <= (ix == '0) ? heap_reg : '0;
        end
        else if (cmd.alloc_write)
        begin
            if (best_len_reg > req_reg.count)
            begin
                ext_start_mem[best_reg] <= best_start_reg + OFF_W'(req_reg.count);
                ext_len_mem[best_reg]   <= best_len_reg - req_reg.count;
            end
            else
            begin
                ext_valid_mem[best_reg] <= 1'b0;
                ext_start_mem[best_reg] <= '0;
                ext_len_mem[best_reg]   <= '0;
            end
        end
        else if (cmd.rel_write && !s_bad)
        begin
            // merge with neighbors or take a spare entry
            if (prev_ok_reg && next_ok_reg)
            begin
                ext_len_mem[prev_reg]   <= prev_len_reg + s_len_reg + next_len_reg;
                ext_valid_mem[next_reg] <= 1'b0;
                ext_start_mem[next_reg] <= '0;
                ext_len_mem[next_reg]   <= '0;
            end
            else if (prev_ok_reg)
            begin
                ext_len_mem[prev_reg] <= prev_len_reg + s_len_reg;
            end
            else if (next_ok_reg)
            begin
                ext_start_mem[next_reg] <= s_off_reg;
                ext_len_mem[next_reg]   <= next_len_reg + s_len_reg;
            end
            else if (spare_ok_reg)
            begin
                ext_start_mem[spare_reg] <= s_off_reg;
                ext_len_mem[spare_reg]   <= s_len_reg;
                ext_valid_mem[spare_reg] <= 1'b1;
            end
        end
        if (cmd.scan_step)
        begin
            cur_v_reg <= ext_valid_mem[ix];
            cur_s_reg <= ext_start_mem[ix];
            cur_l_reg <= ext_len_mem[ix];
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= in_data;
        end
    end

    // stale queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else if (cmd.clear_start)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (cmd.free_push && !stat.stale_full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == STALE_W'(STALE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
                fill_reg   <= fill_reg + 1'b1;
            end
            if (cmd.rel_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == STALE_W'(STALE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
                fill_reg   <= fill_reg - 1'b1;
            end
        end
    end

    // stale queue memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.free_push && !stat.stale_full)
        begin
            stale_start_mem[wr_ptr_reg] <= req_reg.slot_offset;
            stale_len_mem[wr_ptr_reg]   <= req_reg.count;
        end
        if (cmd.rel_load)
        begin
            s_off_reg <= stale_start_mem[rd_ptr_reg];
            s_len_reg <= stale_len_mem[rd_ptr_reg];
        end
    end

    // remember free-push outcome and granted offset
    logic             push_fail_reg;
    logic             granted_reg;
    logic [OFF_W-1:0] grant_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_fail_reg <= 1'b0;
            granted_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                push_fail_reg <= 1'b0;
                granted_reg   <= 1'b0;
            end
            if (cmd.free_push)
            begin
                push_fail_reg <= stat.stale_full;
            end
            if (cmd.alloc_write)
            begin
                granted_reg <= 1'b1;
                grant_reg   <= best_start_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_data.space_ok   <= stat.fit_found;
            out_data.free_slots <= free_reg;
            out_data.grant_offset <= granted_reg ? grant_reg : '0;
            case (req_reg.cmd)
                CMD_ALLOC:   out_data.status <= granted_reg ? ST_OK : ST_NO_SPACE;
                CMD_FREE:    out_data.status <= push_fail_reg ? ST_STALE_FULL : ST_OK;
                CMD_RELEASE: out_data.status <= tfull_reg ? ST_TABLE_FULL : ST_OK;
                default:     out_data.status <= ST_OK;
            endcase
        end
    end

endmodule
